@@ sv/ordered_list_insert_delete_search_assert.svh @@
// assertion macros shared by the checker
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH

// same-cycle implication
`define OLIDS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olids check failed");

// next-cycle implication
`define OLIDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olids check failed");

`endif

@@ sv/olids_pkg.sv @@
`default_nettype none
package olids_pkg;

	localparam int DEPTH = 64;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [1:0] MODE_LOCATE = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic                    found;
		logic [POS_W-1:0]        found_position;
		logic signed [VAL_W-1:0] removed_value;
		logic [POS_W-1:0]        length;
	} out_item_t;

	// broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             cap;
		logic             loc;
		logic             scan;
		logic [CW-1:0]    pidx;
		logic [CW-1:0]    cnt;
		logic [VAL_W-1:0] value;
	} cell_ctrl_t;

	// result slot handed towards cell 0 during a scan
	typedef struct packed {
		logic             hit;
		logic [CW-1:0]    pos;
		logic [VAL_W-1:0] data;
	} slot_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ sv/olids_cell.sv @@
`default_nettype none
module olids_cell
	import olids_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [CW-1:0]    idx,
	input  wire logic [VAL_W-1:0] left_data,
	input  wire logic [VAL_W-1:0] right_data,
	input  wire slot_t            right_slot,
	output logic [VAL_W-1:0]      data,
	output slot_t                 slot
);

	logic [VAL_W-1:0] data_q;
	slot_t            slot_q;
	logic             at_pos;
	logic             past_pos;
	logic             live;

	assign at_pos   = (idx == ctrl.pidx);
	assign past_pos = (idx >= ctrl.pidx);
	assign live     = (idx < ctrl.cnt);

	always_ff @(posedge clk) begin
		if (ctrl.ins && past_pos) begin
			data_q <= at_pos ? ctrl.value : left_data;
		end else if (ctrl.del && past_pos) begin
			data_q <= right_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			slot_q.hit  <= ctrl.loc ? (live && (data_q == ctrl.value)) : (ctrl.del && at_pos);
			slot_q.pos  <= idx + CW'(1);
			slot_q.data <= data_q;
		end else if (ctrl.scan && !slot_q.hit) begin
			slot_q <= right_slot;
		end
	end

	assign data = data_q;
	assign slot = slot_q;

endmodule
`default_nettype wire

@@ sv/ordered_list_insert_delete_search.sv @@
// positional list of up to DEPTH signed 32-bit entries, held one per cell
// input channel: in_valid/in_ready with in_item (mode, position, value)
// output channel: out_valid/out_ready with out_item, one result per item
// items are taken one at a time; in_ready is high only when no item is open
// insert: the cells from the position onward shift at acceptance, then S_DONE loads the result
// delete: cells shift at acceptance, the removed entry travels to cell 0
// locate: every cell compares at acceptance, hits travel to cell 0
// locate and delete pass through S_SCAN when the length n before the item is over one,
// while the result slots move one cell a cycle towards cell 0
// a new item is taken only once the last result is loaded into the output register;
// in_ready returns together with out_valid
// reset clears the length and the control; cell contents need no reset
// a stalled receiver holds out_item; the finished result then waits in the
// block and no new item is taken until the output register frees up
`default_nettype none
module ordered_list_insert_delete_search
	import olids_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	state_t state_q, state_d;

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  steps_q;
	logic [1:0]     pstat_q;
	logic           ploc_q;
	logic           pdel_q;
	logic           out_valid_q;
	out_item_t      out_q;

	logic           accept;
	logic           is_ins;
	logic           is_del;
	logic           is_loc;
	logic [CW-1:0]  pos_w;
	logic [CW-1:0]  pidx;
	logic           ins_bad;
	logic           ins_ok;
	logic           del_ok;
	logic           need_scan;
	logic           load_out;
	logic           scan_en;
	logic [1:0]     stat_d;

	cell_ctrl_t       ctrl;
	logic [VAL_W-1:0] cell_data [DEPTH];
	slot_t            cell_slot [DEPTH];

	assign accept = in_valid && in_ready;

	always_comb begin
		is_ins = 1'b0;
		is_del = 1'b0;
		unique case (in_item.mode)
			MODE_INSERT: is_ins = 1'b1;
			MODE_DELETE: is_del = 1'b1;
			default:     ;
		endcase
	end

	assign is_loc  = !is_ins && !is_del;
	assign pos_w   = CW'(in_item.position);
	assign pidx    = pos_w - CW'(1);
	// position 0 or beyond length+1
	assign ins_bad = (pos_w == '0) || (pidx > count_q);
	assign ins_ok  = is_ins && !ins_bad && (count_q != CW'(DEPTH));
	assign del_ok  = is_del && (pos_w != '0) && (pos_w <= count_q);
	assign need_scan = !is_ins && (count_q > CW'(1));

	always_comb begin
		priority if (is_ins && ins_bad) begin
			stat_d = STAT_RANGE;
		end else if (is_ins && !ins_ok) begin
			stat_d = STAT_FULL;
		end else if (is_del && !del_ok) begin
			stat_d = STAT_RANGE;
		end else begin
			stat_d = STAT_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = need_scan ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (steps_q == CW'(1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		scan_en  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_SCAN:  scan_en = 1'b1;
			S_DONE:  load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && ins_ok) begin
				count_q <= count_q + CW'(1);
			end else if (accept && del_ok) begin
				count_q <= count_q - CW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pstat_q <= stat_d;
			ploc_q  <= is_loc;
			pdel_q  <= is_del;
			steps_q <= count_q - CW'(1);
		end else if (scan_en) begin
			steps_q <= steps_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status         <= pstat_q;
			out_q.found          <= ploc_q && cell_slot[0].hit;
			out_q.found_position <= (ploc_q && cell_slot[0].hit) ?
				POS_W'(cell_slot[0].pos) : '0;
			out_q.removed_value  <= (pdel_q && cell_slot[0].hit) ? cell_slot[0].data : '0;
			out_q.length         <= POS_W'(count_q);
		end
	end

	always_comb begin
		ctrl.ins   = accept && ins_ok;
		ctrl.del   = accept && del_ok;
		ctrl.cap   = accept && !is_ins;
		ctrl.loc   = is_loc;
		ctrl.scan  = scan_en;
		ctrl.pidx  = pidx;
		ctrl.cnt   = count_q;
		ctrl.value = in_item.value;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_d;
		logic [VAL_W-1:0] right_d;
		slot_t            right_s;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
			assign right_s = '0;
		end else begin : g_inner
			assign right_d = cell_data[i+1];
			assign right_s = cell_slot[i+1];
		end

		olids_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.idx        (CW'(i)),
			.left_data  (left_d),
			.right_data (right_d),
			.right_slot (right_s),
			.data       (cell_data[i]),
			.slot       (cell_slot[i])
		);
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

@@ sv/olids_checker.sv @@
`default_nettype none
`include "ordered_list_insert_delete_search_assert.svh"
module olids_checker
	import olids_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_item,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_item
);

	`OLIDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
	`OLIDS_ASSERT_NOW(a_len_bound, out_valid, out_item.length <= POS_W'(DEPTH))
	`OLIDS_ASSERT_NOW(a_found_pos, out_valid, out_item.found == (out_item.found_position != '0))
	`OLIDS_ASSERT_NOW(a_err_clean, out_valid && (out_item.status != STAT_OK), !out_item.found && (out_item.removed_value == '0))

endmodule

bind ordered_list_insert_delete_search olids_checker u_olids_checker (.*);
`default_nettype wire

@@ tb/ordered_list_insert_delete_search_test.sv @@
module ordered_list_insert_delete_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	import olids_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 925;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam int POOL_SIZE = 24;
	localparam int PRINT_LIMIT = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	ordered_list_insert_delete_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// shadow of the list as the block should hold it
	logic signed [VAL_W-1:0] list_entries [DEPTH];
	int list_length = 0;

	in_item_t pending_items [$];
	out_item_t expected_results [$];
	int total_items = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int mismatches = 0;

	int send_wait = 0;
	int send_run = 0;
	int recv_wait = 0;
	int recv_run = 0;
	int idle_cycles = 0;
	int wait_now;
	out_item_t want_item;

	// generator side: the length is tracked, to aim positions, and a pool of recent insert values
	int gen_len = 0;
	logic signed [VAL_W-1:0] value_pool [$];

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic out_item_t apply_list_request(input in_item_t req);
		out_item_t res;
		int pos;
		int k;
		res = '0;
		pos = int'(req.position);
		case (req.mode)
		MODE_INSERT: begin
			if (pos < 1 || pos > list_length + 1) begin
				res.status = STAT_RANGE;
			end else if (list_length >= DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				for (k = list_length; k >= pos; k--)
					list_entries[k] = list_entries[k-1];
				list_entries[pos-1] = req.value;
				list_length++;
			end
		end
		MODE_DELETE: begin
			if (pos < 1 || pos > list_length) begin
				res.status = STAT_RANGE;
			end else begin
				res.removed_value = list_entries[pos-1];
				for (k = pos; k < list_length; k++)
					list_entries[k-1] = list_entries[k];
				list_length--;
			end
		end
		default: begin
			// locate, and the unused mode which behaves the same
			for (k = 0; k < list_length; k++) begin
				if (!res.found && list_entries[k] == req.value) begin
					res.found = 1'b1;
					res.found_position = POS_W'(k + 1);
				end
			end
		end
		endcase
		res.length = POS_W'(list_length);
		return res;
	endfunction

	// idle cycles for the next item, with occasional runs of back-to-back items
	function automatic int draw_gap(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			run = $urandom_range(10, 30);
		return $urandom_range(0, 4);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch on %s: got 0x%08h, expected 0x%08h", what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic push_item(input logic [1:0] m, input int p, input logic [31:0] v);
		in_item_t it;
		it.mode = m;
		it.position = POS_W'(p);
		it.value = v;
		if (m == MODE_INSERT && it.position >= 1 && it.position <= gen_len + 1
				&& gen_len < DEPTH) begin
			gen_len++;
			value_pool.push_back(v);
			if (value_pool.size() > POOL_SIZE)
				void'(value_pool.pop_front());
		end else if (m == MODE_DELETE && it.position >= 1 && it.position <= gen_len) begin
			gen_len--;
		end
		pending_items.push_back(it);
	endtask

	task automatic build_stimulus();
		int i;
		int r;
		int phase;
		int phase_left;
		logic [1:0] m;
		int p;
		logic [31:0] v;

		// directed: empty list, bad positions, extremes, duplicates, unused mode
		push_item(MODE_LOCATE, 0, 32'd5);
		push_item(MODE_DELETE, 1, 32'd0);
		push_item(MODE_INSERT, 0, 32'd7);
		push_item(MODE_INSERT, 2, 32'd7);
		push_item(MODE_INSERT, 1, 32'h8000_0000);
		push_item(MODE_INSERT, 2, 32'h7fff_ffff);
		push_item(MODE_INSERT, 1, 32'd0);
		push_item(MODE_INSERT, 2, 32'hffff_ffff);
		push_item(MODE_INSERT, 5, 32'd0);
		push_item(MODE_INSERT, 7, 32'd1);
		push_item(MODE_INSERT, 127, 32'd1);
		push_item(MODE_LOCATE, 127, 32'd0);
		push_item(MODE_LOCATE, 0, 32'h7fff_ffff);
		push_item(MODE_LOCATE, 3, 32'h8000_0000);
		push_item(MODE_LOCATE, 64, 32'd12345);
		push_item(MODE_UNUSED, 127, 32'hffff_ffff);
		push_item(MODE_UNUSED, 0, 32'd99);
		push_item(MODE_DELETE, 0, 32'hffff_ffff);
		push_item(MODE_DELETE, 6, 32'd0);
		push_item(MODE_DELETE, 127, 32'd0);
		push_item(MODE_DELETE, 3, 32'd0);
		push_item(MODE_DELETE, 4, 32'd0);
		push_item(MODE_DELETE, 1, 32'd0);
		push_item(MODE_LOCATE, 0, 32'd0);

		// random: phases that grow, shrink or churn the list
		phase = 0;
		phase_left = 120;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				phase = $urandom_range(0, 2);
				phase_left = $urandom_range(40, 120);
			end
			phase_left--;
			r = $urandom_range(0, 99);
			case (phase)
			0: m = (r < 75) ? MODE_INSERT : (r < 90) ? MODE_LOCATE : MODE_DELETE;
			1: m = (r < 65) ? MODE_DELETE : (r < 85) ? MODE_LOCATE : MODE_INSERT;
			default: m = (r < 35) ? MODE_INSERT : (r < 70) ? MODE_LOCATE : MODE_DELETE;
			endcase
			if ($urandom_range(0, 24) == 0)
				m = MODE_UNUSED;

			if ($urandom_range(0, 9) == 0 || m == MODE_LOCATE || m == MODE_UNUSED)
				p = $urandom_range(0, 127);
			else if (m == MODE_INSERT)
				p = $urandom_range(1, gen_len + 1);
			else
				p = (gen_len == 0) ? 1 : $urandom_range(1, gen_len);

			r = $urandom_range(0, 9);
			if (r < 5 && value_pool.size() > 0)
				v = value_pool[$urandom_range(0, value_pool.size() - 1)];
			else if (r == 5)
				v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			else
				v = $urandom;
			push_item(m, p, v);
		end
		total_items = pending_items.size();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			send_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(apply_list_request(in_item));
				items_accepted <= items_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
					send_wait <= draw_gap(send_run);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
			results_seen <= 0;
		end else if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result item with nothing expected", out_item[31:0], 32'd0);
			end else begin
				want_item = expected_results.pop_front();
				check_field("status", 32'(out_item.status), 32'(want_item.status));
				check_field("found", 32'(out_item.found), 32'(want_item.found));
				check_field("found_position", 32'(out_item.found_position),
					32'(want_item.found_position));
				check_field("removed_value", out_item.removed_value, want_item.removed_value);
				check_field("length", 32'(out_item.length), 32'(want_item.length));
			end
			results_seen <= results_seen + 1;
			// one long hold-off so the block backs up and stalls its input
			if (results_seen == HOLD_AT)
				wait_now = HOLD_CYCLES;
			else
				wait_now = draw_gap(recv_run);
			recv_wait <= wait_now;
			out_ready <= (wait_now == 0);
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			out_ready <= (recv_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("ordered_list_insert_delete_search regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		build_stimulus();
		@(posedge arst_n);
		while (items_accepted < total_items || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("expected items never delivered", expected_results.size(), 0);
		if (mismatches == 0)
			$display("ordered_list_insert_delete_search regression: pass");
		else
			$display("ordered_list_insert_delete_search regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/olids_pkg.sv
sv/olids_cell.sv
sv/ordered_list_insert_delete_search.sv
sv/olids_checker.sv
tb/ordered_list_insert_delete_search_test.sv
